/* rtl/rail_fence_cipher_defines.svh */
// ----------------------------------------------------------------------------
// Rail fence cipher assertion macros
// Shared property macros used by the top module and the zigzag walker of the rail fence block.
// ----------------------------------------------------------------------------
`ifndef RAIL_FENCE_CIPHER_DEFINES_SVH
`define RAIL_FENCE_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while reset is asserted.
`define RFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rail fence same-cycle check failed");

// Next-cycle implication, sampled on clk_i, quiet while reset is asserted.
`define RFC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rail fence next-cycle check failed");

`endif

/* rtl/rfc_pkg.sv */
// ----------------------------------------------------------------------------
// Rail fence cipher package
// Widths, reset values, codes and shared types of the rail fence block.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

  // Fixed field widths.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RAILS_W = 7;
  // Period of the zigzag is 2*(rails-1), at most 252.
  localparam int unsigned STEP_W  = 8;

  // Default message buffer depth.
  localparam int unsigned MAX_LEN = 64;

  // Register reset values.
  localparam logic [RAILS_W-1:0] RAILS_RESET = 7'd3;
  localparam logic               MODE_RESET  = 1'b0;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_NUM_RAILS    = 1'b0,
    REG_DECRYPT_MODE = 1'b1
  } rfc_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_WAIT,
    ST_ENC_EMIT,
    ST_DEC_COPY,
    ST_DEC_START,
    ST_DEC_EMIT
  } rfc_state_e;

  // Commands from the sequencer to the zigzag walker.
  typedef struct packed {
    logic start;    // load the walker for a new pass
    logic ident;    // walk positions in plain order
    logic advance;  // consume the current position
  } rfc_walk_ctrl_t;

  // Status from the zigzag walker.
  typedef struct packed {
    logic valid;    // current position lies inside the message
    logic last;     // current position is the final one of the pass
    logic done;     // every position of the pass has been consumed
  } rfc_walk_stat_t;

endpackage

`default_nettype wire

/* rtl/rail_fence_cipher.sv */
// ----------------------------------------------------------------------------
// Rail fence cipher
// Buffers a message byte by byte and emits it through a rail fence
// transposition, encrypting or decrypting.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                                        | Direction
//   --------+------------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, in_char_i, in_last_i   | input
//   out     | out_valid_o, out_ready_i, out_char_o,          | output
//           | out_last_o, overflow_o                         |
//   cfg     | cfg_we_i, cfg_addr_i, cfg_wdata_i              | input
//
// While loading, the block accepts a byte whenever one is offered. After the
// last byte the block waits for the output register to drain, then the zigzag
// walker (one shared position adder) emits one byte per cycle, pausing at each
// rail change, for encryption. Decryption first permutes into a second buffer
// with the same walker, then reads it out in order. Output stalls hold the
// walker. Reset restores 3 rails and encryption and empties the buffer count;
// the buffers themselves are not cleared.
//
`default_nettype none

`include "rail_fence_cipher_defines.svh"

module rail_fence_cipher #(
  parameter int unsigned MaxLen = rfc_pkg::MAX_LEN
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration writes.
  input  wire logic                          cfg_we_i,
  input  wire logic [0:0]                    cfg_addr_i,
  input  wire logic [rfc_pkg::RAILS_W-1:0]   cfg_wdata_i,
  // Message bytes in.
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rfc_pkg::CHAR_W-1:0]    in_char_i,
  input  wire logic                          in_last_i,
  // Transposed bytes out.
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [rfc_pkg::CHAR_W-1:0]    out_char_o,
  output logic                               out_last_o,
  output logic                               overflow_o
);

  localparam int unsigned AW = $clog2(MaxLen);
  localparam int unsigned CW = $clog2(MaxLen + 1);
  localparam int unsigned DW = rfc_pkg::CHAR_W;

  rfc_pkg::rfc_state_e     state_q, state_d;
  rfc_pkg::rfc_walk_ctrl_t walk_ctrl;
  rfc_pkg::rfc_walk_stat_t walk_stat;

  logic [rfc_pkg::RAILS_W-1:0] rails_q;
  logic                        mode_q;
  logic [CW-1:0]               count_q;
  logic                        dropped_q;

  logic [AW-1:0] walk_pos;
  logic [AW-1:0] walk_idx;

  logic          in_xfer;
  logic          room;
  logic          out_free;
  logic          msg_we;
  logic          msg_re;
  logic [AW-1:0] msg_raddr;
  logic [DW-1:0] msg_rdata;
  logic          res_re;
  logic [DW-1:0] res_rdata;
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic          out_load;
  logic          out_from_res;
  logic          clear;

  logic          out_valid_q;
  logic          out_last_q;
  logic          out_ovf_q;
  logic          out_sel_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rails_q <= rfc_pkg::RAILS_RESET;
      mode_q  <= rfc_pkg::MODE_RESET;
    end else if (cfg_we_i) begin
      unique case (rfc_pkg::rfc_reg_e'(cfg_addr_i))
        rfc_pkg::REG_NUM_RAILS:    rails_q <= cfg_wdata_i;
        rfc_pkg::REG_DECRYPT_MODE: mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input handshake and buffer write.
  assign in_ready_o = (state_q == rfc_pkg::ST_LOAD);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign room       = (count_q < CW'(MaxLen));
  assign msg_we     = in_xfer && room;
  assign out_free   = !out_valid_q || out_ready_i;

  // Sequencer: next state and per-state controls.
  always_comb begin
    state_d           = state_q;
    walk_ctrl.start   = 1'b0;
    walk_ctrl.ident   = 1'b0;
    walk_ctrl.advance = 1'b0;
    msg_re            = 1'b0;
    msg_raddr         = walk_pos;
    res_re            = 1'b0;
    wr_pend_d         = 1'b0;
    wr_addr_d         = walk_pos;
    out_load          = 1'b0;
    out_from_res      = 1'b0;
    clear             = 1'b0;
    unique case (state_q)
      rfc_pkg::ST_LOAD: begin
        if (in_xfer && in_last_i) begin
          state_d = rfc_pkg::ST_WAIT;
        end
      end
      rfc_pkg::ST_WAIT: begin
        // The read registers double as the output register, so drain first.
        if (!out_valid_q) begin
          walk_ctrl.start = 1'b1;
          state_d = mode_q ? rfc_pkg::ST_DEC_COPY : rfc_pkg::ST_ENC_EMIT;
        end
      end
      rfc_pkg::ST_ENC_EMIT: begin
        msg_re            = walk_stat.valid && out_free;
        walk_ctrl.advance = msg_re;
        out_load          = msg_re;
        if (walk_stat.done) begin
          clear   = 1'b1;
          state_d = rfc_pkg::ST_LOAD;
        end
      end
      rfc_pkg::ST_DEC_COPY: begin
        // Byte k of the message lands at the k-th rail-major position.
        msg_re            = walk_stat.valid;
        msg_raddr         = walk_idx;
        walk_ctrl.advance = walk_stat.valid;
        wr_pend_d         = walk_stat.valid;
        if (walk_stat.done) begin
          state_d = rfc_pkg::ST_DEC_START;
        end
      end
      rfc_pkg::ST_DEC_START: begin
        walk_ctrl.start = 1'b1;
        walk_ctrl.ident = 1'b1;
        state_d         = rfc_pkg::ST_DEC_EMIT;
      end
      rfc_pkg::ST_DEC_EMIT: begin
        res_re            = walk_stat.valid && out_free;
        walk_ctrl.advance = res_re;
        out_load          = res_re;
        out_from_res      = 1'b1;
        if (walk_stat.done) begin
          clear   = 1'b1;
          state_d = rfc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = rfc_pkg::ST_LOAD;
      end
    endcase
  end

  // State, byte count and drop flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rfc_pkg::ST_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_pend_q <= wr_pend_d;
      if (clear) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
      end else if (in_xfer) begin
        if (room) begin
          count_q <= CW'(count_q + CW'(1));
        end else begin
          dropped_q <= 1'b1;
        end
      end
    end
  end

  // Delayed write address for the permutation copy.
  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
  end

  // Output register: valid, flags and source select; data sits in the RAMs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_sel_q   <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      out_last_q  <= walk_stat.last;
      out_ovf_q   <= dropped_q;
      out_sel_q   <= out_from_res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign overflow_o  = out_ovf_q;
  assign out_char_o  = out_sel_q ? res_rdata : msg_rdata;

  // Zigzag walker.
  rfc_walker #(
    .MaxLen (MaxLen)
  ) u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (walk_ctrl),
    .len_i   (count_q),
    .rails_i (rails_q),
    .stat_o  (walk_stat),
    .pos_o   (walk_pos),
    .idx_o   (walk_idx)
  );

  // Message buffer, in arrival order.
  rfc_ram #(
    .Depth (MaxLen),
    .Width (DW)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (msg_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_char_i),
    .re_i    (msg_re),
    .raddr_i (msg_raddr),
    .rdata_o (msg_rdata)
  );

  // Result buffer for decryption, in plaintext order.
  rfc_ram #(
    .Depth (MaxLen),
    .Width (DW)
  ) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pend_q),
    .waddr_i (wr_addr_q),
    .wdata_i (msg_rdata),
    .re_i    (res_re),
    .raddr_i (walk_pos),
    .rdata_o (res_rdata)
  );

  // The byte count never runs past the buffer depth.
  `RFC_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MaxLen))
  // Result buffer writes happen only in the copy state or in the state right after it.
  `RFC_ASSERT_IMP(a_res_write_phase, wr_pend_q,
                  (state_q == rfc_pkg::ST_DEC_COPY) || (state_q == rfc_pkg::ST_DEC_START))
  // A new pass never starts while a result still waits in the output register.
  `RFC_ASSERT_IMP(a_start_drained, walk_ctrl.start && (state_q == rfc_pkg::ST_WAIT),
                  !out_valid_q)

endmodule

`default_nettype wire

/* rtl/rfc_ram.sv */
// ----------------------------------------------------------------------------
// Rail fence byte buffer
// Simple dual-port RAM: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_ram #(
  parameter int unsigned Depth = rfc_pkg::MAX_LEN,
  parameter int unsigned Width = rfc_pkg::CHAR_W
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/rfc_walker.sv */
// ----------------------------------------------------------------------------
// Rail fence zigzag walker
// Steps through message positions rail by rail with one shared position adder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rail_fence_cipher_defines.svh"

module rfc_walker #(
  parameter int unsigned MaxLen = rfc_pkg::MAX_LEN
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rfc_pkg::rfc_walk_ctrl_t       ctrl_i,
  input  wire logic [$clog2(MaxLen+1)-1:0]   len_i,
  input  wire logic [rfc_pkg::RAILS_W-1:0]   rails_i,
  output rfc_pkg::rfc_walk_stat_t            stat_o,
  output logic      [$clog2(MaxLen)-1:0]     pos_o,
  output logic      [$clog2(MaxLen)-1:0]     idx_o
);

  localparam int unsigned AW = $clog2(MaxLen);
  localparam int unsigned CW = $clog2(MaxLen + 1);
  // A position may overshoot the message by up to one period.
  localparam int unsigned PW = $clog2(MaxLen + 2**rfc_pkg::STEP_W);
  localparam int unsigned SW = rfc_pkg::STEP_W;
  localparam int unsigned RW = rfc_pkg::RAILS_W;

  logic [PW-1:0] pos_q, pos_d;
  logic [CW-1:0] k_q, k_d;
  logic [RW-1:0] rail_q, rail_d;
  logic [SW-1:0] period_q, period_d;
  logic [SW-1:0] step_a_q, step_a_d;
  logic [SW-1:0] step_b_q, step_b_d;
  logic          phase_q, phase_d;

  logic          done;
  logic          in_range;
  logic          use_period;
  logic [SW-1:0] step;
  logic [SW-1:0] period_init;
  logic [PW-1:0] pos_sum;
  logic [RW-1:0] rail_nxt;

  // Status of the current position.
  always_comb begin
    done          = (k_q == len_i);
    in_range      = (pos_q < PW'(len_i));
    stat_o.valid  = !done && in_range;
    stat_o.done   = done;
    stat_o.last   = (CW'(k_q + CW'(1)) == len_i);
  end

  assign pos_o = pos_q[AW-1:0];
  assign idx_o = k_q[AW-1:0];

  // Step selection and the shared position adder. Top and bottom rails step
  // by a whole period; middle rails alternate between the two partial steps.
  always_comb begin
    use_period = (step_a_q == '0) || (step_b_q == '0);
    if (use_period) begin
      step = period_q;
    end else if (phase_q) begin
      step = step_b_q;
    end else begin
      step = step_a_q;
    end
    pos_sum  = PW'(pos_q + PW'(step));
    rail_nxt = RW'(rail_q + RW'(1));
    // One rail or none, or the identity walk, walks the message in order with a period of one.
    if (ctrl_i.ident || (rails_i <= RW'(1))) begin
      period_init = SW'(1);
    end else begin
      period_init = SW'({RW'(rails_i - RW'(1)), 1'b0});
    end
  end

  // Next state of the walker.
  always_comb begin
    pos_d    = pos_q;
    k_d      = k_q;
    rail_d   = rail_q;
    period_d = period_q;
    step_a_d = step_a_q;
    step_b_d = step_b_q;
    phase_d  = phase_q;
    priority if (ctrl_i.start) begin
      pos_d    = '0;
      k_d      = '0;
      rail_d   = '0;
      period_d = period_init;
      step_a_d = period_init;
      step_b_d = '0;
      phase_d  = 1'b0;
    end else if (ctrl_i.advance && stat_o.valid) begin
      pos_d   = pos_sum;
      k_d     = CW'(k_q + CW'(1));
      phase_d = !phase_q;
    end else if (!done && !in_range) begin
      // Current rail exhausted: move to the first position of the next rail.
      rail_d   = rail_nxt;
      pos_d    = PW'(rail_nxt);
      step_a_d = SW'(step_a_q - SW'(2));
      step_b_d = SW'(step_b_q + SW'(2));
      phase_d  = 1'b0;
    end else begin
      // Pass finished or position waiting to be consumed: hold.
    end
  end

  // Walker registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      k_q      <= '0;
      rail_q   <= '0;
      period_q <= SW'(1);
      step_a_q <= SW'(1);
      step_b_q <= '0;
      phase_q  <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      k_q      <= k_d;
      rail_q   <= rail_d;
      period_q <= period_d;
      step_a_q <= step_a_d;
      step_b_q <= step_b_d;
      phase_q  <= phase_d;
    end
  end

  // A new pass starts at the first position with nothing consumed.
  `RFC_ASSERT_NXT(a_start_resets, ctrl_i.start, (k_q == '0) && (pos_q == '0))
  // The sequencer consumes a position only when one is offered.
  `RFC_ASSERT_IMP(a_advance_valid, ctrl_i.advance, stat_o.valid)
  // Each consumed position bumps the count by exactly one.
  `RFC_ASSERT_NXT(a_count_step, ctrl_i.advance && !ctrl_i.start,
                  k_q == CW'($past(k_q) + CW'(1)))

endmodule

`default_nettype wire

/* sim/tb_rail_fence_cipher.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rail fence cipher testbench
// Sends messages byte by byte and checks every transposed byte against a
// zigzag predictor beside the block or a directed row's expected byte. A short
// table of directed bytes comes first. Random messages follow under several
// idling patterns, with a long output hold-off, full buffers and dropped bytes.
// ----------------------------------------------------------------------------

module tb_rail_fence_cipher;

  localparam int CLK_HALF     = 6;
  localparam int LIMIT        = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_GAP    = 8;
  localparam int PHASE_ITEMS  = 35;
  localparam int DIR_ROWS     = 22;

  // One transposed byte as it leaves the block.
  typedef struct packed {
    logic [rfc_pkg::CHAR_W-1:0] chr;
    logic                       last;
    logic                       ovf;
  } rf_byte_t;

  // One row of the directed table; cfg asks for a register update first.
  typedef struct packed {
    bit                          cfg;
    logic [rfc_pkg::RAILS_W-1:0] rails;
    bit                          dec;
    logic [rfc_pkg::CHAR_W-1:0]  chr;
    bit                          last;
    bit                          typed;
    logic [rfc_pkg::CHAR_W-1:0]  want;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // Reset setting: three rails, encryption. One-byte messages pass as is.
    '{1'b0, 7'd0,   1'b0, 8'h00, 1'b1, 1'b1, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'hFF, 1'b1, 1'b1, 8'hFF},
    '{1'b0, 7'd0,   1'b0, 8'h41, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h42, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h43, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h44, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h45, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h46, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h47, 1'b1, 1'b0, 8'h00},
    // Zero rails behaves as a single rail.
    '{1'b1, 7'd0,   1'b0, 8'h80, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h01, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h7F, 1'b1, 1'b0, 8'h00},
    // Two rails, decryption.
    '{1'b1, 7'd2,   1'b1, 8'h10, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h20, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h30, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h40, 1'b1, 1'b0, 8'h00},
    // More rails than bytes, where the zigzag never turns, then a one-byte message on one rail.
    '{1'b1, 7'd64,  1'b1, 8'hA5, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'h5A, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'hC3, 1'b1, 1'b0, 8'h00},
    '{1'b1, 7'd127, 1'b0, 8'h01, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   1'b0, 8'hFE, 1'b1, 1'b0, 8'h00},
    '{1'b1, 7'd1,   1'b1, 8'h3C, 1'b1, 1'b1, 8'h3C}
  };

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [0:0]                  cfg_addr_i = rfc_pkg::REG_NUM_RAILS;
  logic [rfc_pkg::RAILS_W-1:0] cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [rfc_pkg::CHAR_W-1:0]  in_char_i = '0;
  logic                        in_last_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [rfc_pkg::CHAR_W-1:0]  out_char_o;
  logic                        out_last_o;
  logic                        overflow_o;

  rail_fence_cipher u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_char_i   (in_char_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o),
    .overflow_o  (overflow_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Predictor state: buffered message, fill count, drop flag and registers.
  logic [rfc_pkg::CHAR_W-1:0]  msg_mem [rfc_pkg::MAX_LEN];
  int unsigned                 msg_len;
  bit                          msg_drop;
  logic [rfc_pkg::RAILS_W-1:0] cur_rails = rfc_pkg::RAILS_RESET;
  bit                          cur_dec = rfc_pkg::MODE_RESET;
  rf_byte_t                    fresh [rfc_pkg::MAX_LEN];
  rf_byte_t                    cipher_q [$];
  rf_byte_t                    want_b;

  int  err_cnt;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_go;
  int  hold_cnt;
  int unsigned cycle_cnt;

  // Rail of a message position on the zigzag.
  function automatic int unsigned zigzag_rail(int unsigned pos, int unsigned rails);
    int unsigned period;
    int unsigned t;
    if (rails <= 1) return 0;
    period = 2 * (rails - 1);
    t = pos % period;
    return (t < rails) ? t : period - t;
  endfunction

  // Buffers one accepted byte; on the last byte, fills fresh[] with the
  // transposed message and returns its length, else returns zero.
  function automatic int transpose_on_byte(logic [rfc_pkg::CHAR_W-1:0] c, bit l);
    int unsigned                walk_pos [rfc_pkg::MAX_LEN];
    logic [rfc_pkg::CHAR_W-1:0] buffer [rfc_pkg::MAX_LEN];
    int unsigned                r, i, k, top, n;
    if (msg_len < rfc_pkg::MAX_LEN) begin
      msg_mem[msg_len] = c;
      msg_len++;
    end else begin
      msg_drop = 1'b1;
    end
    if (!l) return 0;
    n = msg_len;
    k = 0;
    top = (cur_rails <= 1) ? 1 : cur_rails;
    // Positions in rail-major reading order.
    for (r = 0; r < top && k < n; r++) begin
      for (i = 0; i < n; i++) begin
        if (zigzag_rail(i, cur_rails) == r) begin
          walk_pos[k] = i;
          k++;
        end
      end
    end
    for (k = 0; k < n; k++) begin
      if (cur_dec) buffer[walk_pos[k]] = msg_mem[k];
      else buffer[k] = msg_mem[walk_pos[k]];
    end
    for (k = 0; k < n; k++) begin
      fresh[k] = '{buffer[k], (k + 1 == n), msg_drop};
    end
    msg_len = 0;
    msg_drop = 1'b0;
    return n;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Offers one byte and records the bytes it releases once it is accepted.
  task automatic put_byte(logic [rfc_pkg::CHAR_W-1:0] c, bit l, bit typed,
                          logic [rfc_pkg::CHAR_W-1:0] want);
    int n;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= c;
    in_last_i  <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n = transpose_on_byte(c, l);
    if (typed) begin
      cipher_q.push_back('{want, 1'b1, 1'b0});
    end else begin
      for (int k = 0; k < n; k++) cipher_q.push_back(fresh[k]);
    end
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      put_byte(8'($urandom_range(0, 255)), (i == len - 1), 1'b0, '0);
    end
  endtask

  // Waits until every expected byte has left and the block has settled.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // Writes both registers; the mode write carries random upper bits.
  task automatic set_config(logic [rfc_pkg::RAILS_W-1:0] rails, bit dec);
    logic [rfc_pkg::RAILS_W-2:0] pad;
    pad = 6'($urandom_range(0, 63));
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= rfc_pkg::REG_NUM_RAILS;
    cfg_wdata_i <= rails;
    @(posedge clk_i);
    cfg_addr_i  <= rfc_pkg::REG_DECRYPT_MODE;
    cfg_wdata_i <= {pad, dec};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_rails = rails;
    cur_dec = dec;
  endtask

  function automatic logic [rfc_pkg::RAILS_W-1:0] pick_rails();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0: return 7'd0;
        1: return 7'd1;
        2: return 7'd64;
        default: return 7'd127;
      endcase
    end
    if (sel == 1) return 7'($urandom_range(9, 127));
    return 7'($urandom_range(1, 8));
  endfunction

  // Output side: random stalls, plus one long hold-off when requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
      hold_cnt    <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Each output transfer is checked against the oldest expected byte.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cipher_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_char_o));
      end else begin
        want_b = cipher_q.pop_front();
        if (out_char_o !== want_b.chr)
          report_mismatch($sformatf("char %02h, expected %02h", out_char_o, want_b.chr));
        if (out_last_o !== want_b.last)
          report_mismatch($sformatf("last %b, expected %b", out_last_o, want_b.last));
        if (overflow_o !== want_b.ovf)
          report_mismatch($sformatf("overflow %b, expected %b", overflow_o, want_b.ovf));
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb_rail_fence_cipher NOT OK");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    int       sent;
    int       len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, no idling.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      if (row.cfg) begin
        wait_drained();
        set_config(row.rails, row.dec);
      end
      put_byte(row.chr, row.last, row.typed, row.want);
    end
    wait_drained();

    // Random messages under each idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      set_config(pick_rails(), 1'($urandom_range(0, 1)));
      sent = 0;
      // The first pattern opens with the long hold-off so the input backs up.
      if (ph == 0) hold_go <= 1'b1;
      // An overflow that drops the last byte, a full buffer, a longer overflow.
      if (ph == 1) begin send_message(65); sent += 65; end
      if (ph == 2) begin send_message(rfc_pkg::MAX_LEN); sent += rfc_pkg::MAX_LEN; end
      if (ph == 3) begin send_message(67); sent += 67; end
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          wait_drained();
          set_config(pick_rails(), 1'($urandom_range(0, 1)));
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        send_message(len);
        sent += len;
      end
      wait_drained();
    end

    in_valid_i <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) $display("tb_rail_fence_cipher OK");
    else $display("tb_rail_fence_cipher NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rfc_pkg.sv
rtl/rfc_ram.sv
rtl/rfc_walker.sv
rtl/rail_fence_cipher.sv
sim/tb_rail_fence_cipher.sv
